### rtl/core/tlqs_pkg.sv
// Shared types and constants for the two-level queue scheduler.
// No dependencies; imported by every module of the block but the slot table.
`default_nettype none

package tlqs_pkg;

    localparam int SLICE_W   = 16;
    localparam int BURST_W   = 16;
    localparam int LEVEL_W   = 4;
    localparam int SLOT_OUT_W = 4;
    localparam int REPORT_W  = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam int GROUP_W   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_LENGTH   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIORITY_SPLIT = 1'd1;

    localparam logic KIND_ADMIT = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    localparam logic [SLICE_W-1:0]  SLICE_RESET = 16'd4;
    localparam logic [LEVEL_W-1:0]  SPLIT_RESET = 4'd3;

    typedef struct packed {
        logic               kind;
        logic [BURST_W-1:0] burst;
        logic [LEVEL_W-1:0] level;
    } in_item_t;

    typedef struct packed {
        logic                  accepted;
        logic [SLOT_OUT_W-1:0] slot;
        logic                  idle;
        logic                  done_res;
        logic [REPORT_W-1:0]   turnaround;
        logic [REPORT_W-1:0]   waiting;
    } result_t;

    typedef struct packed {
        logic push;
        logic push_fast;
        logic pop;
        logic pop_fast;
    } queue_ctrl_t;

    typedef struct packed {
        logic fast_ready;
        logic slow_ready;
    } queue_status_t;

    typedef struct packed {
        logic set;
        logic clr;
    } used_upd_t;

endpackage

`default_nettype wire

### rtl/core/tlqs_slot_table.sv
// Per-slot job record memory: arrival time, burst and remaining ticks.
// Synchronous read with a registered output. Uses nothing from tlqs_pkg.
`default_nettype none

module tlqs_slot_table #(
    parameter int JOB_SLOTS = 16,
    parameter int WORD_W    = 64
) (
    input  wire logic                         clk,
    input  wire logic                         wr_en,
    input  wire logic [$clog2(JOB_SLOTS)-1:0] wr_addr,
    input  wire logic [WORD_W-1:0]            wr_data,
    input  wire logic                         rd_en,
    input  wire logic [$clog2(JOB_SLOTS)-1:0] rd_addr,
    output logic      [WORD_W-1:0]            rd_data
);

    logic [WORD_W-1:0] mem [0:JOB_SLOTS-1];
    logic [WORD_W-1:0] rd_data_reg;

    // reads and writes never target the same cycle: the sequencer interlocks them
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/core/tlqs_job_queues.sv
// Round-robin and first-come queues sharing one slot-number memory.
// Depends on tlqs_pkg for control and status structs.
`default_nettype none

module tlqs_job_queues #(
    parameter int JOB_SLOTS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  tlqs_pkg::queue_ctrl_t              ctrl,
    input  wire logic [$clog2(JOB_SLOTS)-1:0]  push_slot,
    output tlqs_pkg::queue_status_t            status,
    output logic      [$clog2(JOB_SLOTS)-1:0]  pop_slot
);

    import tlqs_pkg::*;

    localparam int SLOT_W = $clog2(JOB_SLOTS);
    localparam int CNT_W  = SLOT_W + 1;
    localparam logic [SLOT_W-1:0] LAST_PTR = SLOT_W'(JOB_SLOTS - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(JOB_SLOTS);

    logic [SLOT_W-1:0] mem [0:(2 << SLOT_W)-1];
    logic [SLOT_W-1:0] pop_slot_reg;

    logic [SLOT_W-1:0] fast_head_reg, fast_head_next, fast_tail_reg, fast_tail_next;
    logic [SLOT_W-1:0] slow_head_reg, slow_head_next, slow_tail_reg, slow_tail_next;
    logic [CNT_W-1:0]  fast_cnt_reg, fast_cnt_next, slow_cnt_reg, slow_cnt_next;

    logic              push_ok;
    logic [SLOT_W-1:0] wr_ptr;
    logic [SLOT_W-1:0] rd_ptr;

    function automatic logic [SLOT_W-1:0] ptr_inc(input logic [SLOT_W-1:0] p);
        logic [SLOT_W-1:0] r;
        if (p == LAST_PTR)
        begin
            r = '0;
        end
        else
        begin
            r = p + SLOT_W'(1);
        end
        return r;
    endfunction

    assign push_ok = ctrl.push &&
                     (ctrl.push_fast ? (fast_cnt_reg < FULL_CNT) : (slow_cnt_reg < FULL_CNT));
    assign wr_ptr  = ctrl.push_fast ? fast_tail_reg : slow_tail_reg;
    assign rd_ptr  = ctrl.pop_fast ? fast_head_reg : slow_head_reg;

    always_comb
    begin
        fast_head_next = fast_head_reg;
        fast_tail_next = fast_tail_reg;
        fast_cnt_next  = fast_cnt_reg;
        slow_head_next = slow_head_reg;
        slow_tail_next = slow_tail_reg;
        slow_cnt_next  = slow_cnt_reg;
        // push and pop are issued in different sequencer states
        if (push_ok)
        begin
            if (ctrl.push_fast)
            begin
                fast_tail_next = ptr_inc(fast_tail_reg);
                fast_cnt_next  = fast_cnt_reg + CNT_W'(1);
            end
            else
            begin
                slow_tail_next = ptr_inc(slow_tail_reg);
                slow_cnt_next  = slow_cnt_reg + CNT_W'(1);
            end
        end
        else if (ctrl.pop)
        begin
            if (ctrl.pop_fast)
            begin
                fast_head_next = ptr_inc(fast_head_reg);
                fast_cnt_next  = fast_cnt_reg - CNT_W'(1);
            end
            else
            begin
                slow_head_next = ptr_inc(slow_head_reg);
                slow_cnt_next  = slow_cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_head_reg <= '0;
            fast_tail_reg <= '0;
            fast_cnt_reg  <= '0;
            slow_head_reg <= '0;
            slow_tail_reg <= '0;
            slow_cnt_reg  <= '0;
        end
        else
        begin
            fast_head_reg <= fast_head_next;
            fast_tail_reg <= fast_tail_next;
            fast_cnt_reg  <= fast_cnt_next;
            slow_head_reg <= slow_head_next;
            slow_tail_reg <= slow_tail_next;
            slow_cnt_reg  <= slow_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem[{ctrl.push_fast, wr_ptr}] <= push_slot;
        end
        if (ctrl.pop && !push_ok)
        begin
            pop_slot_reg <= mem[{ctrl.pop_fast, rd_ptr}];
        end
    end

    assign pop_slot          = pop_slot_reg;
    assign status.fast_ready = (fast_cnt_reg != '0);
    assign status.slow_ready = (slow_cnt_reg != '0);

endmodule

`default_nettype wire

### rtl/core/tlqs_free_finder.sv
// Slot occupancy bits and a registered two-level lowest-free-slot search.
// Depends on tlqs_pkg for the update struct and group width.
`default_nettype none

module tlqs_free_finder #(
    parameter int JOB_SLOTS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  tlqs_pkg::used_upd_t                upd,
    input  wire logic [$clog2(JOB_SLOTS)-1:0]  upd_slot,
    output logic                               found,
    output logic      [$clog2(JOB_SLOTS)-1:0]  free_slot
);

    import tlqs_pkg::*;

    localparam int SLOT_W = $clog2(JOB_SLOTS);
    localparam int NG     = (JOB_SLOTS + GROUP_W - 1) / GROUP_W;
    localparam int GI_W   = $clog2(GROUP_W);

    logic [JOB_SLOTS-1:0]     used_reg;
    logic [NG*GROUP_W-1:0]    free_pad;
    logic [NG-1:0]            grp_free_reg, grp_free_next;
    logic [GI_W-1:0]          grp_idx_reg [0:NG-1];
    logic [GI_W-1:0]          grp_idx_next [0:NG-1];

    assign free_pad = (NG*GROUP_W)'(~used_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (upd.set)
        begin
            used_reg[upd_slot] <= 1'b1;
        end
        else if (upd.clr)
        begin
            used_reg[upd_slot] <= 1'b0;
        end
    end

    // first level: lowest free bit inside each group of sixteen
    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            grp_free_next[g] = 1'b0;
            grp_idx_next[g]  = '0;
            for (int i = GROUP_W - 1; i >= 0; i--)
            begin
                if (free_pad[g*GROUP_W + i])
                begin
                    grp_free_next[g] = 1'b1;
                    grp_idx_next[g]  = GI_W'(i);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_free_reg <= '0;
        end
        else
        begin
            grp_free_reg <= grp_free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NG; g++)
        begin
            grp_idx_reg[g] <= grp_idx_next[g];
        end
    end

    // second level: lowest group with a free slot
    always_comb
    begin
        found     = 1'b0;
        free_slot = '0;
        for (int g = NG - 1; g >= 0; g--)
        begin
            if (grp_free_reg[g])
            begin
                found     = 1'b1;
                free_slot = SLOT_W'(g*GROUP_W + int'(grp_idx_reg[g]));
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/two_level_queue_scheduler_unit.sv
// Top level of the two-level queue scheduler: event sequencer and registers.
// Depends on tlqs_pkg, tlqs_slot_table, tlqs_job_queues, tlqs_free_finder.
//
//  channel  | ports                                  | handshake
//  ---------+----------------------------------------+--------------------------
//  command  | start, busy, in_item                   | taken when start && !busy
//  result   | done, result                           | one-cycle strobe, no stall
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data | write when valid && ready
//
//  Admit: registered free-slot search, then table and queue write.
//  Tick: idle ends in S_TSEL; running is set by the read of the slot table
//  memory, dispatch by the queue memory and then it, each plus a stage for waiting.
//  The next command is taken in the cycle the result is shown.
//  Reset is asynchronous; occupancy and queue pointers clear at once, slot
//  records are written at admit before any read, so no clearing pass.
`default_nettype none

module two_level_queue_scheduler_unit #(
    parameter int JOB_SLOTS = 16,
    parameter int TIME_BITS = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  tlqs_pkg::in_item_t                       in_item,
    output logic                                     done,
    output tlqs_pkg::result_t                        result,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [tlqs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [tlqs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import tlqs_pkg::*;

    localparam int SLOT_W = $clog2(JOB_SLOTS);
    localparam int WORD_W = TIME_BITS + BURST_W + BURST_W;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ASRCH = 3'd1;
    localparam logic [2:0] S_TPUSH = 3'd2;
    localparam logic [2:0] S_TSEL  = 3'd3;
    localparam logic [2:0] S_TDISP = 3'd4;
    localparam logic [2:0] S_TREAD = 3'd5;
    localparam logic [2:0] S_TEXEC = 3'd6;
    localparam logic [2:0] S_TWAIT = 3'd7;

    logic [2:0]           state_reg, state_next;
    in_item_t             item_reg, item_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic                 running_reg, running_next;
    logic [SLOT_W-1:0]    run_slot_reg, run_slot_next;
    logic                 run_is_fast_reg, run_is_fast_next;
    logic [SLICE_W-1:0]   slice_left_reg, slice_left_next;
    logic                 requeue_pending_reg, requeue_pending_next;
    logic [SLOT_W-1:0]    requeue_slot_reg, requeue_slot_next;
    logic [SLICE_W-1:0]   slice_length_reg, slice_length_next;
    logic [LEVEL_W-1:0]   priority_split_reg, priority_split_next;
    logic [TIME_BITS-1:0] turn_reg, turn_next;
    logic [BURST_W-1:0]   bhold_reg, bhold_next;
    logic                 fin_reg, fin_next;
    result_t              res_reg, res_next;
    logic                 done_reg, done_next;

    queue_ctrl_t          q_ctrl;
    queue_status_t        q_stat;
    logic [SLOT_W-1:0]    q_push_slot;
    logic [SLOT_W-1:0]    q_pop_slot;

    used_upd_t            u_upd;
    logic [SLOT_W-1:0]    u_slot;
    logic                 f_found;
    logic [SLOT_W-1:0]    f_slot;

    logic                 t_wr_en;
    logic [SLOT_W-1:0]    t_wr_addr;
    logic [WORD_W-1:0]    t_wr_data;
    logic                 t_rd_en;
    logic [SLOT_W-1:0]    t_rd_addr;
    logic [WORD_W-1:0]    t_rd_data;

    logic [TIME_BITS-1:0] ex_arrival;
    logic [BURST_W-1:0]   ex_burst;
    logic [BURST_W-1:0]   ex_left;
    logic [BURST_W-1:0]   ex_left_new;
    logic [SLICE_W-1:0]   ex_slice_new;
    logic [TIME_BITS-1:0] now_inc;
    logic                 admit_ok;
    logic                 wt_ge;
    logic [REPORT_W-1:0]  wt_turn;
    logic [REPORT_W-1:0]  wt_wait;

    tlqs_slot_table #(
        .JOB_SLOTS (JOB_SLOTS),
        .WORD_W    (WORD_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (t_wr_en),
        .wr_addr (t_wr_addr),
        .wr_data (t_wr_data),
        .rd_en   (t_rd_en),
        .rd_addr (t_rd_addr),
        .rd_data (t_rd_data)
    );

    tlqs_job_queues #(
        .JOB_SLOTS (JOB_SLOTS)
    ) u_queues (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (q_ctrl),
        .push_slot (q_push_slot),
        .status    (q_stat),
        .pop_slot  (q_pop_slot)
    );

    tlqs_free_finder #(
        .JOB_SLOTS (JOB_SLOTS)
    ) u_finder (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd       (u_upd),
        .upd_slot  (u_slot),
        .found     (f_found),
        .free_slot (f_slot)
    );

    assign ex_arrival   = t_rd_data[WORD_W-1 -: TIME_BITS];
    assign ex_burst     = t_rd_data[2*BURST_W-1 -: BURST_W];
    assign ex_left      = t_rd_data[BURST_W-1:0];
    assign ex_left_new  = (ex_left != '0) ? ex_left - BURST_W'(1) : ex_left;
    assign ex_slice_new = (run_is_fast_reg && slice_left_reg != '0) ?
                          slice_left_reg - SLICE_W'(1) : slice_left_reg;
    assign now_inc      = (now_reg == TIME_MAX) ? now_reg : now_reg + TIME_BITS'(1);
    assign admit_ok     = f_found && (item_reg.burst != '0);

    assign wt_turn = REPORT_W'(turn_reg);
    assign wt_ge   = (64'(turn_reg) >= 64'(bhold_reg));
    assign wt_wait = wt_ge ? wt_turn - REPORT_W'(bhold_reg) : '0;

    always_comb
    begin
        state_next           = state_reg;
        item_next            = item_reg;
        now_next             = now_reg;
        running_next         = running_reg;
        run_slot_next        = run_slot_reg;
        run_is_fast_next     = run_is_fast_reg;
        slice_left_next      = slice_left_reg;
        requeue_pending_next = requeue_pending_reg;
        requeue_slot_next    = requeue_slot_reg;
        slice_length_next    = slice_length_reg;
        priority_split_next  = priority_split_reg;
        turn_next            = turn_reg;
        bhold_next           = bhold_reg;
        fin_next             = fin_reg;
        res_next             = res_reg;
        done_next            = 1'b0;

        q_ctrl      = '0;
        q_push_slot = f_slot;
        u_upd       = '0;
        u_slot      = f_slot;
        t_wr_en     = 1'b0;
        t_wr_addr   = f_slot;
        t_wr_data   = {now_reg, item_reg.burst, item_reg.burst};
        t_rd_en     = 1'b0;
        t_rd_addr   = run_slot_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SLICE_LENGTH:   slice_length_next   = cfg_data[SLICE_W-1:0];
                CFG_PRIORITY_SPLIT: priority_split_next = cfg_data[LEVEL_W-1:0];
                default:            slice_length_next   = slice_length_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next = in_item;
                    if (in_item.kind == KIND_ADMIT)
                    begin
                        state_next = S_ASRCH;
                    end
                    else if (requeue_pending_reg)
                    begin
                        state_next = S_TPUSH;
                    end
                    else if (running_reg)
                    begin
                        state_next = S_TREAD;
                    end
                    else
                    begin
                        state_next = S_TSEL;
                    end
                end
            end
            S_ASRCH:
            begin
                res_next  = '0;
                done_next = 1'b1;
                if (admit_ok)
                begin
                    q_ctrl.push      = 1'b1;
                    q_ctrl.push_fast = (item_reg.level < priority_split_reg);
                    u_upd.set        = 1'b1;
                    t_wr_en          = 1'b1;
                    res_next.accepted = 1'b1;
                    res_next.slot     = SLOT_OUT_W'(f_slot);
                end
                state_next = S_IDLE;
            end
            S_TPUSH:
            begin
                q_ctrl.push          = 1'b1;
                q_ctrl.push_fast     = 1'b1;
                q_push_slot          = requeue_slot_reg;
                requeue_pending_next = 1'b0;
                state_next           = S_TSEL;
            end
            S_TSEL:
            begin
                if (q_stat.fast_ready || q_stat.slow_ready)
                begin
                    q_ctrl.pop       = 1'b1;
                    q_ctrl.pop_fast  = q_stat.fast_ready;
                    run_is_fast_next = q_stat.fast_ready;
                    if (q_stat.fast_ready)
                    begin
                        slice_left_next = (slice_length_reg != '0) ?
                                          slice_length_reg : SLICE_W'(1);
                    end
                    state_next = S_TDISP;
                end
                else
                begin
                    now_next      = now_inc;
                    res_next      = '0;
                    res_next.idle = 1'b1;
                    done_next     = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_TDISP:
            begin
                run_slot_next = q_pop_slot;
                running_next  = 1'b1;
                t_rd_en       = 1'b1;
                t_rd_addr     = q_pop_slot;
                state_next    = S_TEXEC;
            end
            S_TREAD:
            begin
                t_rd_en    = 1'b1;
                state_next = S_TEXEC;
            end
            S_TEXEC:
            begin
                now_next        = now_inc;
                slice_left_next = ex_slice_new;
                t_wr_en         = 1'b1;
                t_wr_addr       = run_slot_reg;
                t_wr_data       = {ex_arrival, ex_burst, ex_left_new};
                turn_next       = now_inc - ex_arrival;
                bhold_next      = ex_burst;
                fin_next        = (ex_left_new == '0);
                if (ex_left_new == '0)
                begin
                    u_upd.clr    = 1'b1;
                    u_slot       = run_slot_reg;
                    running_next = 1'b0;
                end
                else if (run_is_fast_reg && ex_slice_new == '0)
                begin
                    requeue_pending_next = 1'b1;
                    requeue_slot_next    = run_slot_reg;
                    running_next         = 1'b0;
                end
                state_next = S_TWAIT;
            end
            S_TWAIT:
            begin
                res_next            = '0;
                res_next.slot       = SLOT_OUT_W'(run_slot_reg);
                res_next.done_res   = fin_reg;
                res_next.turnaround = fin_reg ? wt_turn : '0;
                res_next.waiting    = fin_reg ? wt_wait : '0;
                done_next           = 1'b1;
                state_next          = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            now_reg             <= '0;
            running_reg         <= 1'b0;
            run_slot_reg        <= '0;
            run_is_fast_reg     <= 1'b0;
            slice_left_reg      <= '0;
            requeue_pending_reg <= 1'b0;
            requeue_slot_reg    <= '0;
            slice_length_reg    <= SLICE_RESET;
            priority_split_reg  <= SPLIT_RESET;
            done_reg            <= 1'b0;
        end
        else
        begin
            state_reg           <= state_next;
            now_reg             <= now_next;
            running_reg         <= running_next;
            run_slot_reg        <= run_slot_next;
            run_is_fast_reg     <= run_is_fast_next;
            slice_left_reg      <= slice_left_next;
            requeue_pending_reg <= requeue_pending_next;
            requeue_slot_reg    <= requeue_slot_next;
            slice_length_reg    <= slice_length_next;
            priority_split_reg  <= priority_split_next;
            done_reg            <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        turn_reg  <= turn_next;
        bhold_reg <= bhold_next;
        fin_reg   <= fin_next;
        res_reg   <= res_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = res_reg;

endmodule

`default_nettype wire

### rtl/core/tlqs_checker.sv
// Port-level checks on the scheduler's command and result channels.
// Depends on tlqs_pkg; bound to two_level_queue_scheduler_unit below.
`default_nettype none

module tlqs_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic                            busy,
    input  wire logic                            done,
    input  tlqs_pkg::result_t                    result
);

    import tlqs_pkg::*;

    // a taken transaction always occupies the sequencer next cycle
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("command taken but block not busy");

    // at most one result per transaction, never on consecutive cycles
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe on back-to-back cycles");

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result with no transaction in flight");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.idle |-> !result.done_res && !result.accepted && result.slot == '0)
        else $error("idle tick reports a job");

    a_no_stats: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.done_res |-> result.turnaround == '0 && result.waiting == '0)
        else $error("times reported without completion");

endmodule

bind two_level_queue_scheduler_unit tlqs_checker u_tlqs_checker (.*);

`default_nettype wire

### tb/tb_two_level_queue_scheduler_unit.sv
// Self-checking testbench for two_level_queue_scheduler_unit: directed and random
// admit/tick commands with register changes between phases, checked against a scheduler model.
// Depends on tlqs_pkg and the RTL of the block only.

module tb_two_level_queue_scheduler_unit;

    import tlqs_pkg::*;

    localparam int SLOT_COUNT  = 16;
    localparam int STALL_LIMIT = 2000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    in_item_t              in_item = '0;
    logic                  done;
    result_t               result;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    two_level_queue_scheduler_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .in_item   (in_item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // scheduler model
    logic [SLICE_W-1:0] slice_cfg = SLICE_RESET;
    logic [LEVEL_W-1:0] split_cfg = SPLIT_RESET;
    logic [31:0]        clock_now = '0;
    logic               slot_busy [SLOT_COUNT];
    logic [31:0]        slot_arrived [SLOT_COUNT];
    logic [15:0]        slot_len [SLOT_COUNT];
    logic [15:0]        slot_remain [SLOT_COUNT];
    logic [3:0]         fast_line [$];
    logic [3:0]         slow_line [$];
    logic               cpu_busy = 1'b0;
    logic [3:0]         run_idx = '0;
    logic               run_fast = 1'b0;
    logic [15:0]        slice_remain = '0;
    logic               requeue_pend = 1'b0;
    logic [3:0]         requeue_idx = '0;

    in_item_t           event_backlog [$];
    result_t            pending_reports [$];
    int                 queued_count = 0;
    int                 taken_count = 0;
    int                 stall_cycles = 0;
    int                 errors = 0;
    int                 gap_pct = 16;
    logic               cmd_fired = 1'b0;

    initial
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            slot_busy[i] = 1'b0;
        end
    end

    function automatic void bump_clock();
        if (clock_now != 32'hFFFF_FFFF)
        begin
            clock_now = clock_now + 1;
        end
    endfunction

    function automatic result_t schedule_event(in_item_t ev);
        result_t     r;
        int          s;
        logic [31:0] span;
        r = '0;
        s = -1;
        if (ev.kind == KIND_ADMIT)
        begin
            for (int i = SLOT_COUNT - 1; i >= 0; i--)
            begin
                if (!slot_busy[i])
                begin
                    s = i;
                end
            end
            if (ev.burst != 0 && s >= 0)
            begin
                slot_busy[s]    = 1'b1;
                slot_arrived[s] = clock_now;
                slot_len[s]     = ev.burst;
                slot_remain[s]  = ev.burst;
                if (ev.level < split_cfg)
                begin
                    if (fast_line.size() < SLOT_COUNT)
                    begin
                        fast_line = {fast_line, 4'(s)};
                    end
                end
                else if (slow_line.size() < SLOT_COUNT)
                begin
                    slow_line = {slow_line, 4'(s)};
                end
                r.accepted = 1'b1;
                r.slot     = 4'(s);
            end
        end
        else
        begin
            if (requeue_pend)
            begin
                if (fast_line.size() < SLOT_COUNT)
                begin
                    fast_line = {fast_line, requeue_idx};
                end
                requeue_pend = 1'b0;
            end
            if (!cpu_busy)
            begin
                if (fast_line.size() > 0)
                begin
                    run_idx      = fast_line.pop_front();
                    run_fast     = 1'b1;
                    slice_remain = (slice_cfg == 0) ? 16'd1 : slice_cfg;
                    cpu_busy     = 1'b1;
                end
                else if (slow_line.size() > 0)
                begin
                    run_idx  = slow_line.pop_front();
                    run_fast = 1'b0;
                    cpu_busy = 1'b1;
                end
            end
            if (!cpu_busy)
            begin
                r.idle = 1'b1;
                bump_clock();
            end
            else
            begin
                r.slot = run_idx;
                if (slot_remain[run_idx] > 0)
                begin
                    slot_remain[run_idx] = slot_remain[run_idx] - 1;
                end
                bump_clock();
                if (run_fast && slice_remain > 0)
                begin
                    slice_remain = slice_remain - 1;
                end
                if (slot_remain[run_idx] == 0)
                begin
                    span         = clock_now - slot_arrived[run_idx];
                    r.done_res   = 1'b1;
                    r.turnaround = span;
                    r.waiting    = (span >= 32'(slot_len[run_idx]))
                                   ? span - 32'(slot_len[run_idx]) : 32'd0;
                    slot_busy[run_idx] = 1'b0;
                    cpu_busy = 1'b0;
                end
                else if (run_fast && slice_remain == 0)
                begin
                    requeue_pend = 1'b1;
                    requeue_idx  = run_idx;
                    cpu_busy     = 1'b0;
                end
            end
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // monitor: results are checked before the transaction taken at the same edge is modelled
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            cmd_fired = start && !busy;
            if (done)
            begin
                if (pending_reports.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, result);
                    errors++;
                end
                else
                begin
                    want = pending_reports.pop_front();
                    check_field("accepted", 32'(want.accepted), 32'(result.accepted));
                    check_field("slot", 32'(want.slot), 32'(result.slot));
                    check_field("idle", 32'(want.idle), 32'(result.idle));
                    check_field("done_res", 32'(want.done_res), 32'(result.done_res));
                    check_field("turnaround", want.turnaround, result.turnaround);
                    check_field("waiting", want.waiting, result.waiting);
                end
            end
            if (cmd_fired)
            begin
                pending_reports = {pending_reports, schedule_event(in_item)};
                taken_count++;
            end
            if (done || cmd_fired || (cfg_valid && cfg_ready))
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("tb_two_level_queue_scheduler_unit failed");
                $finish;
            end
        end
    end

    // command driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!start || cmd_fired)
        begin
            if (event_backlog.size() > 0 && $urandom_range(99) >= gap_pct)
            begin
                in_item <= event_backlog.pop_front();
                start   <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    function automatic in_item_t make_admit(logic [15:0] burst, logic [3:0] level);
        in_item_t ev;
        ev.kind  = KIND_ADMIT;
        ev.burst = burst;
        ev.level = level;
        return ev;
    endfunction

    function automatic in_item_t make_tick();
        in_item_t ev;
        ev.kind  = KIND_TICK;
        ev.burst = 16'($urandom_range(16'hFFFF));
        ev.level = 4'($urandom_range(15));
        return ev;
    endfunction

    function automatic in_item_t random_event(int admit_pct);
        in_item_t ev;
        int       pick;
        ev = make_tick();
        if ($urandom_range(99) < admit_pct)
        begin
            ev.kind = KIND_ADMIT;
            pick = $urandom_range(99);
            if (pick < 3)
            begin
                ev.burst = '0;
            end
            else if (pick < 8)
            begin
                ev.burst = 16'($urandom_range(40, 8));
            end
            else
            begin
                ev.burst = 16'($urandom_range(5, 1));
            end
        end
        return ev;
    endfunction

    task automatic queue_event(in_item_t ev);
        event_backlog = {event_backlog, ev};
        queued_count++;
    endtask

    task automatic wait_drained();
        while (taken_count != queued_count || pending_reports.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        if (idx == CFG_SLICE_LENGTH)
        begin
            slice_cfg = val;
        end
        else
        begin
            split_cfg = val[LEVEL_W-1:0];
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int n, int admit_pct);
        repeat (n)
        begin
            queue_event(random_event(admit_pct));
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: slice 4, split 3
        queue_event(make_tick());
        queue_event(make_admit(16'd0, 4'd0));
        queue_event(make_admit(16'd1, 4'd0));
        queue_event(make_admit(16'd6, 4'd15));
        queue_event(make_admit(16'd5, 4'd2));
        repeat (5) queue_event(make_tick());
        // fresh admit must queue ahead of the preempted job
        queue_event(make_admit(16'd2, 4'd1));
        repeat (4) queue_event(make_tick());
        // running slow job is not preempted by a fast arrival
        queue_event(make_admit(16'd3, 4'd0));
        repeat (9) queue_event(make_tick());
        wait_drained();

        write_reg(CFG_SLICE_LENGTH, 16'd1);
        write_reg(CFG_PRIORITY_SPLIT, 16'd15);
        random_phase(200, 20);

        // zero quantum behaves as one; no command gaps here
        gap_pct = 0;
        write_reg(CFG_SLICE_LENGTH, 16'd0);
        write_reg(CFG_PRIORITY_SPLIT, 16'd8);
        random_phase(150, 20);
        gap_pct = 16;

        write_reg(CFG_SLICE_LENGTH, 16'hFFFF);
        write_reg(CFG_PRIORITY_SPLIT, 16'd0);
        random_phase(150, 20);

        // fill the table, then admits with wide bursts are refused
        write_reg(CFG_SLICE_LENGTH, 16'd2);
        write_reg(CFG_PRIORITY_SPLIT, 16'd4);
        repeat (16) queue_event(make_admit(16'($urandom_range(3, 1)), 4'($urandom_range(15))));
        queue_event(make_admit(16'hFFFF, 4'd15));
        queue_event(make_admit(16'($urandom_range(16'hFFFF, 1)), 4'd0));
        queue_event(make_admit(16'($urandom_range(16'hFFFF, 1)), 4'($urandom_range(15))));
        queue_event(make_admit(16'h8000, 4'($urandom_range(15))));
        repeat (140) queue_event(make_tick());
        wait_drained();

        write_reg(CFG_SLICE_LENGTH, 16'($urandom_range(9, 2)));
        write_reg(CFG_PRIORITY_SPLIT, 16'($urandom_range(15)));
        random_phase(200, 25);

        write_reg(CFG_SLICE_LENGTH, 16'd3);
        write_reg(CFG_PRIORITY_SPLIT, 16'd15);
        random_phase(165, 20);

        repeat (20) @(posedge clk);
        if (pending_reports.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, pending_reports.size());
        end
        if (errors == 0 && pending_reports.size() == 0)
        begin
            $display("tb_two_level_queue_scheduler_unit passed");
        end
        else
        begin
            $display("tb_two_level_queue_scheduler_unit failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/tlqs_pkg.sv
rtl/core/tlqs_slot_table.sv
rtl/core/tlqs_job_queues.sv
rtl/core/tlqs_free_finder.sv
rtl/core/two_level_queue_scheduler_unit.sv
rtl/core/tlqs_checker.sv
tb/tb_two_level_queue_scheduler_unit.sv
